// ===== hw/rtl/roof_lock_motion_controller_top_assert.svh =====
// assertion macros for the roof and lock motion controller
`ifndef ROOF_LOCK_MOTION_CONTROLLER_TOP_ASSERT_SVH
`define ROOF_LOCK_MOTION_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, idle during reset
`define RLMC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("rlmc check failed");

// next-cycle implication, idle during reset
`define RLMC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("rlmc check failed");

`endif

// ===== hw/rtl/rlmc_pkg.sv =====
// shared types and constants for the roof and lock motion controller
package rlmc_pkg;

    typedef enum logic [2:0] {
        MODE_UNKNOWN  = 3'd0,
        MODE_RAISING  = 3'd1,
        MODE_LOWERING = 3'd2,
        MODE_RAISED   = 3'd3,
        MODE_LOWERED  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYNC = 2'd1,
        PH_CMD  = 2'd2
    } t_phase;

    localparam logic [7:0] SYNC_CODE    = 8'h50;
    localparam logic [7:0] OP_ROOF_UP   = 8'hAB;
    localparam logic [7:0] OP_ROOF_DOWN = 8'hCD;
    localparam logic [7:0] OP_ROOF_HALT = 8'hEF;
    localparam logic [7:0] OP_LOCK_ON   = 8'h12;
    localparam logic [7:0] OP_LOCK_OFF  = 8'h34;
    localparam logic [7:0] OP_LOCK_HALT = 8'h56;
    localparam logic [7:0] OP_ALIVE     = 8'hF1;

    localparam int unsigned TIMEOUT_W   = 6;
    localparam int unsigned ELAPSED_W   = 16;
    localparam int unsigned MS_PER_S    = 1000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 6'd10;
    // travel completes once elapsed reaches (timeout + 1) seconds
    localparam logic [ELAPSED_W-1:0] LIMIT_RESET =
        ELAPSED_W'((int'(TIMEOUT_RESET) + 1) * MS_PER_S);

    typedef struct packed {
        logic       tick_ms;
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic       upper_switch_a;
        logic       upper_switch_b;
        logic       lower_switch_a;
        logic       lower_switch_b;
    } t_in_req;

    typedef struct packed {
        logic       roof_raise_drive;
        logic       roof_lower_drive;
        logic       lock_engage_drive;
        logic       lock_release_drive;
        logic [2:0] roof_motion;
        logic [2:0] lock_motion;
    } t_out_req;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } t_cmd;

endpackage

// ===== hw/rtl/rlmc_framer.sv =====
// serial framer: three sync bytes then one command byte
module rlmc_framer import rlmc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_byte_valid,
    input  logic [7:0] i_rx_byte,
    output t_cmd       o_cmd
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [1:0] r_sync_seen;
    logic [1:0] n_sync_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_sync_seen <= 2'd0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_sync_seen <= n_sync_seen;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_sync_seen = r_sync_seen;
        o_cmd.valid = 1'b0;
        o_cmd.code  = i_rx_byte;
        if (i_byte_valid) begin
            case (r_phase)
                PH_SYNC: begin
                    if (i_rx_byte != SYNC_CODE) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_sync_seen = r_sync_seen + 2'd1;
                        if (n_sync_seen == 2'd3) begin
                            n_phase = PH_CMD;
                        end
                    end
                end
                PH_CMD: begin
                    n_phase     = PH_IDLE;
                    o_cmd.valid = 1'b1;
                end
                default: begin
                    if (i_rx_byte == SYNC_CODE) begin
                        n_sync_seen = 2'd1;
                        n_phase     = PH_SYNC;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/rlmc_motion.sv =====
// roof and lock motion state, limit rules, command handling
module rlmc_motion import rlmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  t_in_req              i_req,
    input  t_cmd                 i_cmd,
    input  logic [ELAPSED_W-1:0] i_lock_limit,
    output t_out_req             o_next
);

    t_mode                r_roof;
    t_mode                r_lock;
    logic [ELAPSED_W-1:0] r_elapsed;
    t_mode                n_roof;
    t_mode                n_lock;
    logic [ELAPSED_W-1:0] n_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roof    <= MODE_UNKNOWN;
            r_lock    <= MODE_UNKNOWN;
            r_elapsed <= '0;
        end else if (i_adv) begin
            r_roof    <= n_roof;
            r_lock    <= n_lock;
            r_elapsed <= n_elapsed;
        end
    end

    always_comb begin
        logic up;
        logic down;
        logic lock_ok;
        up   = i_req.upper_switch_a | i_req.upper_switch_b;
        down = i_req.lower_switch_a | i_req.lower_switch_b;

        // saturating travel counter
        n_elapsed = r_elapsed;
        if (i_req.tick_ms && (r_elapsed != '1)) begin
            n_elapsed = r_elapsed + ELAPSED_W'(1);
        end

        n_lock = r_lock;
        if (n_elapsed >= i_lock_limit) begin
            case (r_lock)
                MODE_RAISING:  n_lock = MODE_RAISED;
                MODE_LOWERING: n_lock = MODE_LOWERED;
                default:       n_lock = r_lock;
            endcase
        end

        // limit switch rules in order
        n_roof = r_roof;
        if ((n_roof != MODE_LOWERING) && up) begin
            n_roof = MODE_RAISED;
        end
        if ((n_roof != MODE_RAISING) && down) begin
            n_roof = MODE_LOWERED;
        end
        if ((n_roof == MODE_LOWERED) && !down) begin
            n_roof = MODE_UNKNOWN;
        end
        if ((n_roof == MODE_RAISED) && !up) begin
            n_roof = MODE_UNKNOWN;
        end

        lock_ok = (n_lock == MODE_LOWERED) || (n_lock == MODE_UNKNOWN);
        if (i_cmd.valid) begin
            case (i_cmd.code)
                OP_ROOF_UP: begin
                    if ((n_roof != MODE_RAISED) && lock_ok) begin
                        n_roof = MODE_RAISING;
                    end
                end
                OP_ROOF_DOWN: begin
                    if ((n_roof != MODE_LOWERED) && lock_ok) begin
                        n_roof = MODE_LOWERING;
                    end
                end
                OP_ROOF_HALT: n_roof = MODE_UNKNOWN;
                OP_LOCK_ON: begin
                    if (n_lock != MODE_RAISED) begin
                        n_lock    = MODE_RAISING;
                        n_elapsed = '0;
                    end
                end
                OP_LOCK_OFF: begin
                    if (n_lock != MODE_LOWERED) begin
                        n_lock    = MODE_LOWERING;
                        n_elapsed = '0;
                    end
                end
                OP_LOCK_HALT: n_lock = MODE_UNKNOWN;
                OP_ALIVE:     n_lock = n_lock;
                default:      n_roof = n_roof;
            endcase
        end

        o_next.roof_raise_drive   = (n_roof == MODE_RAISING);
        o_next.roof_lower_drive   = (n_roof == MODE_LOWERING);
        o_next.lock_engage_drive  = (n_lock == MODE_RAISING);
        o_next.lock_release_drive = (n_lock == MODE_LOWERING);
        o_next.roof_motion        = n_roof;
        o_next.lock_motion        = n_lock;
    end

endmodule

// ===== hw/rtl/roof_lock_motion_controller_top.sv =====
// top level of the roof and lock motion controller
// Each request is one control pass and yields one result request. A request
// is taken into an input register, evaluated against the roof, lock and
// framer state, and the result lands in an output register, so one request
// per cycle is sustained while i_out_ready does not stall the output. The
// lock timeout write also precomputes the travel limit in milliseconds, so
// a pass needs only a counter and one compare.
module roof_lock_motion_controller_top import rlmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_req             o_out_req,
    input  logic                 i_cfg_we,
    input  logic [TIMEOUT_W-1:0] i_cfg_wdata
);

`include "roof_lock_motion_controller_top_assert.svh"

    logic                 r_in_valid;
    t_in_req              r_in_req;
    logic                 r_out_valid;
    t_out_req             r_out_req;
    logic [ELAPSED_W-1:0] r_lock_limit;
    logic                 out_free;
    logic                 adv;
    t_cmd                 cmd;
    t_out_req             n_out_req;

    assign out_free    = !r_out_valid || i_out_ready;
    assign adv         = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_lock_limit <= ELAPSED_W'((ELAPSED_W'(i_cfg_wdata) + ELAPSED_W'(1))
                                       * ELAPSED_W'(MS_PER_S));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_req <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_req <= n_out_req;
        end
    end

    rlmc_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_byte_valid (r_in_req.byte_valid),
        .i_rx_byte    (r_in_req.rx_byte),
        .o_cmd        (cmd)
    );

    rlmc_motion u_motion (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_req        (r_in_req),
        .i_cmd        (cmd),
        .i_lock_limit (r_lock_limit),
        .o_next       (n_out_req)
    );

    `RLMC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !out_free,
        r_in_valid && $stable(r_in_req))
    `RLMC_ASSERT_NEXT(a_adv_gives_out, i_clk, i_rst_n, adv, r_out_valid)
    `RLMC_ASSERT_NOW(a_roof_drive_excl, i_clk, i_rst_n, r_out_valid,
        !(r_out_req.roof_raise_drive && r_out_req.roof_lower_drive))
    `RLMC_ASSERT_NOW(a_lock_drive_match, i_clk, i_rst_n, r_out_valid,
        r_out_req.lock_engage_drive == (r_out_req.lock_motion == MODE_RAISING))

endmodule
